/* src/ifce_pkg.sv */
`timescale 1ns / 1ps

package ifce_pkg;

    // Field widths
    localparam int CMD_W      = 3;
    localparam int ADDR_W     = 25;
    localparam int WORD_W     = ADDR_W - 1;
    localparam int DATA_W     = 8;
    localparam int SIG_W      = 2;
    localparam int FRAME_W    = 32;
    localparam int CODE_W     = 2;
    localparam int PAGE_CFG_W = 4;

    // Largest page is 2**MAX_PAGE_LOG2 bytes; the offset field spans that many bits
    localparam int MAX_PAGE_LOG2 = 9;
    localparam int PAGE_BITS     = MAX_PAGE_LOG2;
    localparam logic [PAGE_CFG_W-1:0] PAGE_LOG2_MIN   = PAGE_CFG_W'(1);
    localparam logic [PAGE_CFG_W-1:0] PAGE_LOG2_MAX   = PAGE_CFG_W'(MAX_PAGE_LOG2);
    localparam logic [PAGE_CFG_W-1:0] PAGE_LOG2_RESET = PAGE_CFG_W'(7);

    // Job queue between front and back
    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    // Request codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ENABLE      = 3'd0,
        CMD_SIGNATURE   = 3'd1,
        CMD_READ_BYTE   = 3'd2,
        CMD_WRITE_BYTE  = 3'd3,
        CMD_ERASE       = 3'd4,
        CMD_RESET_CACHE = 3'd5
    } t_cmd;

    // Reply position codes
    localparam logic [CODE_W-1:0] ANS_NONE = 2'd0;
    localparam logic [CODE_W-1:0] ANS_ECHO = 2'd1;
    localparam logic [CODE_W-1:0] ANS_DATA = 2'd2;

    // Wait codes
    localparam logic [CODE_W-1:0] WAIT_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] WAIT_ERASE = 2'd1;
    localparam logic [CODE_W-1:0] WAIT_PAGE  = 2'd2;

    // Instruction bytes
    localparam logic [7:0] OP_PROG_EN    = 8'hAC;
    localparam logic [7:0] OP_ECHO       = 8'h53;
    localparam logic [7:0] OP_SIGNATURE  = 8'h30;
    localparam logic [7:0] OP_ERASE_ARG  = 8'h80;
    localparam logic [7:0] OP_LOAD_EXT   = 8'h4D;
    localparam logic [7:0] OP_READ_HI    = 8'h28;
    localparam logic [7:0] OP_READ_LO    = 8'h20;
    localparam logic [7:0] OP_LOAD_HI    = 8'h48;
    localparam logic [7:0] OP_LOAD_LO    = 8'h40;
    localparam logic [7:0] OP_COMMIT     = 8'h4C;

    typedef struct packed {
        logic [FRAME_W-1:0] word;
        logic [CODE_W-1:0]  answer;
        logic [CODE_W-1:0]  wait_code;
    } t_frame;

    // One request after classification: one frame, optionally a second
    typedef struct packed {
        t_frame f0;
        logic   has_f1;
        t_frame f1;
    } t_job;

    function automatic t_frame make_frame(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [CODE_W-1:0] answer,
                                          input logic [CODE_W-1:0] wait_code);
        t_frame f;
        f.word      = {b0, b1, b2, b3};
        f.answer    = answer;
        f.wait_code = wait_code;
        return f;
    endfunction

endpackage

/* src/ifce_queue.sv */
`timescale 1ns / 1ps

module ifce_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ifce_pkg::t_job i_wdata,
    output logic          o_full,
    output logic          o_valid,
    output ifce_pkg::t_job o_rdata,
    input  logic          i_pop
);
    import ifce_pkg::*;

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [JOB_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [JOB_CNT_W-1:0] r_count, n_count;
    logic                 do_push, do_pop;

    assign o_full  = (r_count == JOB_CNT_W'(JOB_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= JOB_CNT_W'(JOB_DEPTH))
        else $error("job queue count overflow");

endmodule

/* src/ifce_front.sv */
`timescale 1ns / 1ps

module ifce_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ifce_pkg::PAGE_CFG_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [ifce_pkg::CMD_W-1:0]      i_command,
    input  logic [ifce_pkg::ADDR_W-1:0]     i_byte_address,
    input  logic [ifce_pkg::DATA_W-1:0]     i_data_byte,
    input  logic [ifce_pkg::SIG_W-1:0]      i_signature_index,
    output logic                           o_job_push,
    output ifce_pkg::t_job                  o_job,
    input  logic                           i_job_full
);
    import ifce_pkg::*;

    localparam logic [PAGE_BITS-1:0] PAGE_ONES = '1;

    logic [PAGE_CFG_W-1:0] r_page_log2;
    logic [7:0]            r_ext_cached, n_ext_cached;
    logic                  r_ext_valid, n_ext_valid;

    logic                  accept;
    logic [PAGE_CFG_W-1:0] lg;
    logic [PAGE_BITS-1:0]  mask, off;
    logic [ADDR_W-1:0]     page_base;
    logic [WORD_W-1:0]     wa, pw;
    logic [7:0]            ext;
    logic                  ext_hit, need_ext, page_open, page_close;
    logic [7:0]            rd_op, wr_op;
    t_frame                ext_frame, rd_frame, wr_frame, commit_frame;
    t_job                  job;
    logic                  job_push;

    assign o_cfg_ready = 1'b1;
    assign full        = i_job_full;
    assign accept      = push && !i_job_full;

    // Page size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_log2 <= PAGE_LOG2_RESET;
        end else if (i_cfg_valid) begin
            r_page_log2 <= i_cfg_data;
        end
    end

    // Page geometry, clamped to the supported range
    always_comb begin
        if (r_page_log2 < PAGE_LOG2_MIN) begin
            lg = PAGE_LOG2_MIN;
        end else if (r_page_log2 > PAGE_LOG2_MAX) begin
            lg = PAGE_LOG2_MAX;
        end else begin
            lg = r_page_log2;
        end
    end

    assign mask      = ~(PAGE_ONES << lg);
    assign off       = i_byte_address[PAGE_BITS-1:0] & mask;
    assign page_base = {i_byte_address[ADDR_W-1:PAGE_BITS],
                        i_byte_address[PAGE_BITS-1:0] & ~mask};
    assign wa        = i_byte_address[ADDR_W-1:1];
    assign pw        = page_base[ADDR_W-1:1];
    // page base and byte address share the bits above the page offset
    assign ext       = wa[23:16];
    assign ext_hit   = r_ext_valid && (ext == r_ext_cached);
    assign page_open  = (off == '0);
    assign page_close = (off == mask);

    assign rd_op = i_byte_address[0] ? OP_READ_HI : OP_READ_LO;
    assign wr_op = i_byte_address[0] ? OP_LOAD_HI : OP_LOAD_LO;

    assign ext_frame    = make_frame(OP_LOAD_EXT, 8'h00, ext, 8'h00, ANS_NONE, WAIT_NONE);
    assign rd_frame     = make_frame(rd_op, wa[15:8], wa[7:0], 8'h00, ANS_DATA, WAIT_NONE);
    assign wr_frame     = make_frame(wr_op, 8'h00, wa[7:0], i_data_byte, ANS_NONE, WAIT_NONE);
    assign commit_frame = make_frame(OP_COMMIT, pw[15:8], pw[7:0], 8'h00,
                                     ANS_NONE, WAIT_PAGE);

    // Classify the request into a job of one or two frames; cache reset and unused codes push none
    always_comb begin
        job          = '0;
        job_push     = 1'b0;
        need_ext     = 1'b0;
        n_ext_cached = r_ext_cached;
        n_ext_valid  = r_ext_valid;
        case (t_cmd'(i_command))
            CMD_ENABLE: begin
                job.f0   = make_frame(OP_PROG_EN, OP_ECHO, 8'h00, 8'h00, ANS_ECHO, WAIT_NONE);
                job_push = 1'b1;
            end
            CMD_SIGNATURE: begin
                job.f0   = make_frame(OP_SIGNATURE, 8'h00, 8'(i_signature_index), 8'h00,
                                      ANS_DATA, WAIT_NONE);
                job_push = 1'b1;
            end
            CMD_READ_BYTE: begin
                need_ext   = !ext_hit;
                job.f0     = need_ext ? ext_frame : rd_frame;
                job.has_f1 = need_ext;
                job.f1     = rd_frame;
                job_push   = 1'b1;
            end
            CMD_WRITE_BYTE: begin
                need_ext   = page_open && !ext_hit;
                job.f0     = need_ext ? ext_frame : wr_frame;
                job.has_f1 = need_ext || page_close;
                job.f1     = need_ext ? wr_frame : commit_frame;
                job_push   = 1'b1;
            end
            CMD_ERASE: begin
                job.f0       = make_frame(OP_PROG_EN, OP_ERASE_ARG, 8'h00, 8'h00,
                                          ANS_NONE, WAIT_ERASE);
                job_push     = 1'b1;
                n_ext_cached = '0;
                n_ext_valid  = 1'b0;
            end
            CMD_RESET_CACHE: begin
                n_ext_cached = '0;
                n_ext_valid  = 1'b0;
            end
            default: begin
            end
        endcase
        if (need_ext) begin
            n_ext_cached = ext;
            n_ext_valid  = 1'b1;
        end
    end

    assign o_job      = job;
    assign o_job_push = accept && job_push;

    // Extended address cache, updated in request order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_cached <= '0;
            r_ext_valid  <= 1'b0;
        end else if (accept) begin
            r_ext_cached <= n_ext_cached;
            r_ext_valid  <= n_ext_valid;
        end
    end

    a_erase_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_command == CMD_ERASE || i_command == CMD_RESET_CACHE)
        |=> !r_ext_valid && (r_ext_cached == '0))
        else $error("cache not invalidated by erase or reset");

    a_read_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_command == CMD_READ_BYTE) |=> r_ext_valid)
        else $error("cache not valid after read");

endmodule

/* src/ifce_back.sv */
`timescale 1ns / 1ps

module ifce_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  ifce_pkg::t_job               i_job,
    output logic                        o_job_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [ifce_pkg::FRAME_W-1:0] o_frame_word,
    output logic [ifce_pkg::CODE_W-1:0]  o_answer_position,
    output logic [ifce_pkg::CODE_W-1:0]  o_wait_after,
    output logic                        o_last_frame
);
    import ifce_pkg::*;

    logic   r_sel, n_sel;
    logic   r_out_valid, n_out_valid;
    t_frame r_frame, n_frame;
    logic   r_last, n_last;
    logic   out_take, load, done;

    assign out_take = pop && r_out_valid;
    assign load     = i_job_valid && (!r_out_valid || out_take);

    // Pick the next frame of the head job
    always_comb begin
        if (!r_sel) begin
            n_frame = i_job.f0;
            done    = !i_job.has_f1;
        end else begin
            n_frame = i_job.f1;
            done    = 1'b1;
        end
        n_last = done;

        n_sel = r_sel;
        if (load) begin
            n_sel = !done;
        end

        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_job_pop = load && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_frame <= n_frame;
            r_last  <= n_last;
        end
    end

    assign empty             = !r_out_valid;
    assign o_frame_word      = r_frame.word;
    assign o_answer_position = r_frame.answer;
    assign o_wait_after      = r_frame.wait_code;
    assign o_last_frame      = r_last;

    a_sel_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> i_job_valid)
        else $error("second frame pending without a job");

    a_wait_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_frame.wait_code != WAIT_NONE) |-> r_last)
        else $error("wait frame is not the last of its request");

endmodule

/* src/isp_flash_command_encoder.sv */
`timescale 1ns / 1ps

// Serial-programming frame encoder.
// Requests enter through push/full: a transfer happens when push is high and
// full is low. Each request yields zero, one or two 32-bit frames, read through
// empty/pop: the oldest frame sits on o_frame_word and its side fields while
// empty is low, and pop takes it. o_last_frame marks the final frame of a request.
// The page size register is written through i_cfg_valid/o_cfg_ready (always ready)
// and must only change while no request is in flight.
// A request taken through push is written into the job queue and then loaded into
// the output register, where its first frame appears. The back end emits one frame
// per cycle while pop stays high, so the frames of a request go out back to back;
// the front end takes a request each cycle while the two-entry job queue has room.
// When the receiver stalls, the output register and then the job queue fill,
// and full rises; nothing is dropped.
// Reset (synchronous, active low) empties the job queue and the output register,
// sets the page size to 128 bytes and invalidates the extended address cache.
module isp_flash_command_encoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ifce_pkg::PAGE_CFG_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [ifce_pkg::CMD_W-1:0]      i_command,
    input  logic [ifce_pkg::ADDR_W-1:0]     i_byte_address,
    input  logic [ifce_pkg::DATA_W-1:0]     i_data_byte,
    input  logic [ifce_pkg::SIG_W-1:0]      i_signature_index,
    output logic                           empty,
    input  logic                           pop,
    output logic [ifce_pkg::FRAME_W-1:0]    o_frame_word,
    output logic [ifce_pkg::CODE_W-1:0]     o_answer_position,
    output logic [ifce_pkg::CODE_W-1:0]     o_wait_after,
    output logic                           o_last_frame
);
    import ifce_pkg::*;

    logic job_push, job_full, job_valid, job_pop;
    t_job job_in, job_head;

    ifce_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .push              (push),
        .full              (full),
        .i_command         (i_command),
        .i_byte_address    (i_byte_address),
        .i_data_byte       (i_data_byte),
        .i_signature_index (i_signature_index),
        .o_job_push        (job_push),
        .o_job             (job_in),
        .i_job_full        (job_full)
    );

    ifce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_wdata (job_in),
        .o_full  (job_full),
        .o_valid (job_valid),
        .o_rdata (job_head),
        .i_pop   (job_pop)
    );

    ifce_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_valid       (job_valid),
        .i_job             (job_head),
        .o_job_pop         (job_pop),
        .empty             (empty),
        .pop               (pop),
        .o_frame_word      (o_frame_word),
        .o_answer_position (o_answer_position),
        .o_wait_after      (o_wait_after),
        .o_last_frame      (o_last_frame)
    );

endmodule

/* test/tb_isp_flash_command_encoder.sv */
`timescale 1ns / 1ps

module tb_isp_flash_command_encoder;
    import ifce_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int LONG_HOLD       = 300;
    localparam int TARGET_REQUESTS = 270;
    localparam int MAX_REPORTS     = 40;

    // Codes outside the request set; the block must ignore them
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [SIG_W-1:0]  sig;
    } t_request;

    typedef struct packed {
        logic [FRAME_W-1:0] word;
        logic [CODE_W-1:0]  answer;
        logic [CODE_W-1:0]  wait_code;
        logic               last;
    } t_expected_frame;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [PAGE_CFG_W-1:0] i_cfg_data;
    logic                  push;
    logic                  full;
    logic [CMD_W-1:0]      i_command;
    logic [ADDR_W-1:0]     i_byte_address;
    logic [DATA_W-1:0]     i_data_byte;
    logic [SIG_W-1:0]      i_signature_index;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [FRAME_W-1:0]    o_frame_word;
    logic [CODE_W-1:0]     o_answer_position;
    logic [CODE_W-1:0]     o_wait_after;
    logic                  o_last_frame;

    // Mirror of the block state
    logic [PAGE_CFG_W-1:0] page_log2_cfg = PAGE_LOG2_RESET;
    logic [7:0]            ext_cached = 8'h00;
    logic                  ext_loaded = 1'b0;

    t_expected_frame frames_due[$];
    int  error_count   = 0;
    int  requests_sent = 0;
    int  cycle_count   = 0;
    bit  tx_steady     = 1'b0;
    bit  rx_steady     = 1'b0;
    int  rx_gap        = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    int  hold_left     = 0;
    logic [7:0] region_byte = 8'h00;

    isp_flash_command_encoder i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .push              (push),
        .full              (full),
        .i_command         (i_command),
        .i_byte_address    (i_byte_address),
        .i_data_byte       (i_data_byte),
        .i_signature_index (i_signature_index),
        .empty             (empty),
        .pop               (pop),
        .o_frame_word      (o_frame_word),
        .o_answer_position (o_answer_position),
        .o_wait_after      (o_wait_after),
        .o_last_frame      (o_last_frame)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d frames still due", $time, frames_due.size());
            $display("tb_isp_flash_command_encoder NOT OK");
            $finish;
        end
    end

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit steady);
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Out-of-range settings act as the nearest legal page size
    function automatic int effective_page_log2();
        if (page_log2_cfg < PAGE_LOG2_MIN) return int'(PAGE_LOG2_MIN);
        if (page_log2_cfg > PAGE_LOG2_MAX) return int'(PAGE_LOG2_MAX);
        return int'(page_log2_cfg);
    endfunction

    function automatic logic [ADDR_W-1:0] page_mask();
        logic [ADDR_W-1:0] m;
        m = ADDR_W'(1);
        m = (m << effective_page_log2()) - 1'b1;
        return m;
    endfunction

    function automatic t_expected_frame frame_of(input logic [FRAME_W-1:0] word,
                                                 input logic [CODE_W-1:0] answer,
                                                 input logic [CODE_W-1:0] wait_code);
        t_expected_frame f;
        f.word      = word;
        f.answer    = answer;
        f.wait_code = wait_code;
        f.last      = 1'b0;
        return f;
    endfunction

    // Extended address cache: a load frame only when the high byte changes
    function automatic bit ext_load_needed(input logic [7:0] ext);
        if (ext_loaded && ext == ext_cached) return 1'b0;
        ext_cached = ext;
        ext_loaded = 1'b1;
        return 1'b1;
    endfunction

    // Frames a request produces, appended to frames_due in order
    function automatic void encode_request(input t_request r);
        t_expected_frame  batch[3];
        int               n;
        logic [WORD_W-1:0] wa;
        logic [WORD_W-1:0] pw;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] base;
        n    = 0;
        wa   = r.addr[ADDR_W-1:1];
        mask = page_mask();
        off  = r.addr & mask;
        base = r.addr & ~mask;
        pw   = base[ADDR_W-1:1];
        case (r.cmd)
            CMD_ENABLE: begin
                batch[n] = frame_of({OP_PROG_EN, OP_ECHO, 8'h00, 8'h00}, ANS_ECHO, WAIT_NONE);
                n++;
            end
            CMD_SIGNATURE: begin
                batch[n] = frame_of({OP_SIGNATURE, 8'h00, 6'b0, r.sig, 8'h00},
                                    ANS_DATA, WAIT_NONE);
                n++;
            end
            CMD_READ_BYTE: begin
                if (ext_load_needed(wa[23:16])) begin
                    batch[n] = frame_of({OP_LOAD_EXT, 8'h00, wa[23:16], 8'h00},
                                        ANS_NONE, WAIT_NONE);
                    n++;
                end
                batch[n] = frame_of({r.addr[0] ? OP_READ_HI : OP_READ_LO,
                                     wa[15:8], wa[7:0], 8'h00}, ANS_DATA, WAIT_NONE);
                n++;
            end
            CMD_WRITE_BYTE: begin
                // page start opens the page, top offset commits it
                if (off == 0 && ext_load_needed(pw[23:16])) begin
                    batch[n] = frame_of({OP_LOAD_EXT, 8'h00, pw[23:16], 8'h00},
                                        ANS_NONE, WAIT_NONE);
                    n++;
                end
                batch[n] = frame_of({r.addr[0] ? OP_LOAD_HI : OP_LOAD_LO,
                                     8'h00, wa[7:0], r.data}, ANS_NONE, WAIT_NONE);
                n++;
                if (off == mask) begin
                    batch[n] = frame_of({OP_COMMIT, pw[15:8], pw[7:0], 8'h00},
                                        ANS_NONE, WAIT_PAGE);
                    n++;
                end
            end
            CMD_ERASE: begin
                ext_loaded = 1'b0;
                ext_cached = 8'h00;
                batch[n] = frame_of({OP_PROG_EN, OP_ERASE_ARG, 8'h00, 8'h00},
                                    ANS_NONE, WAIT_ERASE);
                n++;
            end
            CMD_RESET_CACHE: begin
                ext_loaded = 1'b0;
                ext_cached = 8'h00;
            end
            default: ;
        endcase
        if (n > 0) batch[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) frames_due.push_back(batch[i]);
    endfunction

    function automatic void report_field(input string name, input logic [FRAME_W-1:0] want,
                                         input logic [FRAME_W-1:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    // Receiver: random pop pattern, long holds on request, checks each transfer
    always @(posedge i_clk) begin
        t_expected_frame due;
        if (!i_rst_n) begin
            pop    <= 1'b0;
            rx_gap = 0;
        end else begin
            if (pop && !empty) begin
                if (frames_due.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: frame expected none actual %h", $time, o_frame_word);
                end else begin
                    due = frames_due.pop_front();
                    report_field("frame_word", due.word, o_frame_word);
                    report_field("answer_position", FRAME_W'(due.answer),
                                 FRAME_W'(o_answer_position));
                    report_field("wait_after", FRAME_W'(due.wait_code),
                                 FRAME_W'(o_wait_after));
                    report_field("last_frame", FRAME_W'(due.last), FRAME_W'(o_last_frame));
                end
            end
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                if (pop && !empty)
                    rx_gap = pick_gap(rx_steady);
                else if (!pop && rx_gap > 0)
                    rx_gap--;
                pop <= (rx_gap == 0);
            end
        end
    end

    function automatic t_request make_request(input logic [CMD_W-1:0] cmd,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [DATA_W-1:0] data,
                                              input logic [SIG_W-1:0] sig);
        t_request r;
        r.cmd  = cmd;
        r.addr = addr;
        r.data = data;
        r.sig  = sig;
        return r;
    endfunction

    function automatic t_request random_request();
        logic [31:0] raw;
        t_request    r;
        raw    = $urandom();
        r.cmd  = CMD_W'($urandom_range(0, 7));
        r.addr = raw[ADDR_W-1:0];
        r.data = DATA_W'($urandom_range(0, 255));
        r.sig  = SIG_W'($urandom_range(0, 3));
        return r;
    endfunction

    // Page base, often in the same extended region as the last one
    function automatic logic [ADDR_W-1:0] pick_page_base();
        logic [31:0]       raw;
        logic [ADDR_W-1:0] a;
        raw = $urandom();
        a   = raw[ADDR_W-1:0];
        if ($urandom_range(0, 1))
            a[24:17] = region_byte;
        else
            region_byte = a[24:17];
        return a & ~page_mask();
    endfunction

    // One request transfer; the random gap comes before the item
    task automatic send_request(input t_request r);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push              <= 1'b1;
        i_command         <= r.cmd;
        i_byte_address    <= r.addr;
        i_data_byte       <= r.data;
        i_signature_index <= r.sig;
        do @(posedge i_clk); while (full);
        encode_request(r);
        requests_sent++;
    endtask

    // Wait for every due frame, then for any request that makes none
    task automatic wait_until_idle();
        push <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_page_size(input logic [PAGE_CFG_W-1:0] value);
        wait_until_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        page_log2_cfg = value;
    endtask

    // Sequential page fill for small pages; start, two middles and top for large ones
    task automatic program_page(input logic [ADDR_W-1:0] base);
        int page_bytes;
        int n_writes;
        int off;
        page_bytes = 1 << effective_page_log2();
        n_writes   = (page_bytes <= 16) ? page_bytes : 4;
        for (int i = 0; i < n_writes; i++) begin
            if (page_bytes <= 16) off = i;
            else if (i == 0) off = 0;
            else if (i == n_writes - 1) off = page_bytes - 1;
            else off = $urandom_range(1, page_bytes - 2);
            send_request(make_request(CMD_WRITE_BYTE, base | ADDR_W'(off),
                                      DATA_W'($urandom_range(0, 255)), 2'd0));
        end
    endtask

    task automatic test_directed_cases();
        send_request(make_request(CMD_ENABLE, 25'h0, 8'h00, 2'd0));
        for (int s = 0; s < 4; s++)
            send_request(make_request(CMD_SIGNATURE, 25'h0, 8'h00, SIG_W'(s)));
        // read with an empty cache, then a hit on the same region
        send_request(make_request(CMD_READ_BYTE, 25'h0000000, 8'h00, 2'd0));
        send_request(make_request(CMD_READ_BYTE, 25'h0000001, 8'h00, 2'd0));
        send_request(make_request(CMD_READ_BYTE, 25'h1FFFFFF, 8'h00, 2'd3));
        send_request(make_request(CMD_READ_BYTE, 25'h1FFFFFE, 8'h00, 2'd0));
        // page at zero: open, middle, commit
        send_request(make_request(CMD_WRITE_BYTE, 25'h0000000, 8'hA5, 2'd0));
        send_request(make_request(CMD_WRITE_BYTE, 25'h0000001, 8'h5A, 2'd0));
        send_request(make_request(CMD_WRITE_BYTE, 25'h000007F, 8'hFF, 2'd0));
        // top page of the address space
        send_request(make_request(CMD_WRITE_BYTE, 25'h1FFFF80, 8'h00, 2'd0));
        send_request(make_request(CMD_WRITE_BYTE, 25'h1FFFFFF, 8'hFF, 2'd0));
        // erase and cache reset both force a new load
        send_request(make_request(CMD_ERASE, 25'h1FFFFFF, 8'hFF, 2'd3));
        send_request(make_request(CMD_READ_BYTE, 25'h1FFFFFF, 8'h00, 2'd0));
        send_request(make_request(CMD_RESET_CACHE, 25'h0, 8'h00, 2'd0));
        send_request(make_request(CMD_READ_BYTE, 25'h1FFFFFF, 8'h00, 2'd0));
        send_request(make_request(CMD_UNUSED_6, 25'h1FFFFFF, 8'hFF, 2'd3));
        send_request(make_request(CMD_UNUSED_7, 25'h0000000, 8'h00, 2'd0));
        // unaligned write in the middle of a page
        send_request(make_request(CMD_WRITE_BYTE, 25'h0000155, 8'h3C, 2'd0));
        send_request(make_request(CMD_ENABLE, 25'h1FFFFFF, 8'hFF, 2'd3));
        wait_until_idle();
    endtask

    task automatic test_page_programs();
        logic [PAGE_CFG_W-1:0] settings[8];
        logic [31:0]           raw;
        settings = '{4'd1, 4'd0, 4'd2, 4'd9, 4'd15, 4'd10, 4'd3, 4'd4};
        foreach (settings[i]) begin
            write_page_size(settings[i]);
            program_page(pick_page_base());
            raw = $urandom();
            send_request(make_request(CMD_READ_BYTE, {region_byte, raw[16:0]}, 8'h00, 2'd0));
            program_page(pick_page_base());
        end
        wait_until_idle();
    endtask

    // Receiver stops for a long stretch while requests keep coming
    task automatic test_backpressure();
        write_page_size(4'd2);
        hold_requests <= hold_requests + 1;
        tx_steady = 1'b1;
        for (int i = 0; i < 30; i++) begin
            if (i % 4 == 0)
                program_page(pick_page_base());
            else
                send_request(random_request());
        end
        tx_steady = 1'b0;
        wait_until_idle();
    endtask

    task automatic test_random_mix();
        int          roll;
        logic [31:0] raw;
        write_page_size(PAGE_LOG2_RESET);
        while (requests_sent < TARGET_REQUESTS) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                write_page_size(PAGE_CFG_W'($urandom_range(0, 15)));
            end else if (roll < 10) begin
                tx_steady = ($urandom_range(0, 2) == 0);
                rx_steady = ($urandom_range(0, 2) == 0);
            end else if (roll < 55) begin
                program_page(pick_page_base());
            end else if (roll < 75) begin
                raw = $urandom();
                send_request(make_request(CMD_READ_BYTE, {region_byte, raw[16:0]},
                                          raw[31:24], raw[18:17]));
            end else begin
                send_request(random_request());
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_data        <= '0;
        push              <= 1'b0;
        i_command         <= '0;
        i_byte_address    <= '0;
        i_data_byte       <= '0;
        i_signature_index <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_page_programs();
        test_backpressure();
        test_random_mix();
        wait_until_idle();

        if (error_count == 0)
            $display("tb_isp_flash_command_encoder OK");
        else
            $display("tb_isp_flash_command_encoder NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
src/ifce_pkg.sv
src/ifce_queue.sv
src/ifce_front.sv
src/ifce_back.sv
src/isp_flash_command_encoder.sv
test/tb_isp_flash_command_encoder.sv
